FILE: hw/rtl/assert_macros.svh
// Assertion macros included by the top level, which carries the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHECK_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define CHECK_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("next-cycle check failed");

`endif

FILE: hw/rtl/brf_pkg.sv
// Shared constants, codes and command type of the byte ring FIFO.
package brf_pkg;

   localparam int DEPTH = 256;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;
   localparam int CSR_ADDR_W = 3;

   // operation codes
   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_GET   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // register indexes
   localparam logic REG_QUEUE_SIZE = 1'b0;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
   } brf_cmd_type;

endpackage

FILE: hw/rtl/brf_ctrl.sv
// Sequencing state machine of the byte ring FIFO.
module brf_ctrl import brf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_valid,
   output brf_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   // a new word may enter while the previous result is on the ports
   assign busy   = (state_ff == ST_EXEC);
   assign accept = start && !busy;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_valid = (state_ff == ST_RESP);
   assign cmd.load  = accept;
   assign cmd.exec  = (state_ff == ST_EXEC);

endmodule

FILE: hw/rtl/brf_datapath.sv
// Store, positions, count and result registers of the byte ring FIFO.
module brf_datapath import brf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  brf_cmd_type      cmd,
   input  logic [1:0]       req_kind,
   input  logic [7:0]       req_data_in,
   input  logic [CNT_W-1:0] queue_size,
   output logic [7:0]       rsp_data_out,
   output logic             rsp_get_missed,
   output logic             rsp_put_dropped,
   output logic             rsp_is_empty,
   output logic             rsp_is_full,
   output logic [CNT_W-1:0] rsp_fill_count
);

   logic [7:0]       store_ff [DEPTH];
   logic [1:0]       kind_ff;
   logic [7:0]       data_ff;
   logic [PTR_W-1:0] wr_pos_ff, wr_pos_in;
   logic [PTR_W-1:0] rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [7:0]       rdata_ff;
   logic             got_ff, got_in;
   logic             missed_ff, missed_in;
   logic             dropped_ff, dropped_in;
   logic [CNT_W-1:0] size_eff;
   logic             do_put;

   // next position, wrapping at the effective size
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] pos,
                                                input logic [CNT_W-1:0] size);
      logic [CNT_W-1:0] nxt;
      nxt = {1'b0, pos} + CNT_W'(1);
      if (nxt >= size) return '0;
      return nxt[PTR_W-1:0];
   endfunction

   // size clamped to 1..DEPTH
   always_comb begin
      if (queue_size == '0)
         size_eff = CNT_W'(1);
      else if (queue_size > CNT_W'(DEPTH))
         size_eff = CNT_W'(DEPTH);
      else
         size_eff = queue_size;
   end

   // latch the word at accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         data_ff <= req_data_in;
      end
   end

   // operation decode
   always_comb begin
      wr_pos_in  = wr_pos_ff;
      rd_pos_in  = rd_pos_ff;
      held_in    = held_ff;
      got_in     = 1'b0;
      missed_in  = 1'b0;
      dropped_in = 1'b0;
      do_put     = 1'b0;
      case (kind_ff)
         KIND_PUT: begin
            if (held_ff < size_eff) begin
               do_put    = 1'b1;
               wr_pos_in = advance(wr_pos_ff, size_eff);
               held_in   = held_ff + CNT_W'(1);
            end else begin
               dropped_in = 1'b1;
            end
         end
         KIND_GET: begin
            if (held_ff != '0) begin
               got_in    = 1'b1;
               rd_pos_in = advance(rd_pos_ff, size_eff);
               held_in   = held_ff - CNT_W'(1);
            end else begin
               missed_in = 1'b1;
            end
         end
         KIND_CLEAR: begin
            wr_pos_in = '0;
            rd_pos_in = '0;
            held_in   = '0;
         end
         default: begin
         end
      endcase
   end

   // queue state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         rd_pos_ff <= '0;
         held_ff   <= '0;
      end else if (cmd.exec) begin
         wr_pos_ff <= wr_pos_in;
         rd_pos_ff <= rd_pos_in;
         held_ff   <= held_in;
      end
   end

   // result flags
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         got_ff     <= got_in;
         missed_ff  <= missed_in;
         dropped_ff <= dropped_in;
      end
   end

   // byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.exec && do_put) store_ff[wr_pos_ff] <= data_ff;
      if (cmd.exec) rdata_ff <= store_ff[rd_pos_ff];
   end

   assign rsp_data_out    = got_ff ? rdata_ff : 8'd0;
   assign rsp_get_missed  = missed_ff;
   assign rsp_put_dropped = dropped_ff;
   assign rsp_is_empty    = (held_ff == '0);
   assign rsp_is_full     = (held_ff >= size_eff);
   assign rsp_fill_count  = held_ff;

endmodule

FILE: hw/rtl/byte_ring_fifo_unit.sv
// Top level of the byte ring FIFO: register port, controller and datapath.
//
// Byte FIFO on a 256-entry circular store. A word (put, get or clear) is
// taken when start is high and busy is low; it passes through the execute
// state and then the result state, and its result appears on the rsp_ ports
// for exactly one cycle under rsp_valid; the receiver cannot stall it. In
// the execute state the store is written or read into a register; busy is
// high only in the execute state, so the next word can be taken during the
// result state, while the last result is still on the ports. There is no
// clearing pass after reset. queue_size (address 0, reset 256, clamped to
// 1..256) should be written only while idle and be followed by a clear.
`include "assert_macros.svh"
module byte_ring_fifo_unit import brf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_kind,
   input  logic [7:0]            req_data_in,
   // result channel
   output logic                  rsp_valid,
   output logic [7:0]            rsp_data_out,
   output logic                  rsp_get_missed,
   output logic                  rsp_put_dropped,
   output logic                  rsp_is_empty,
   output logic                  rsp_is_full,
   output logic [CNT_W-1:0]      rsp_fill_count,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [CNT_W-1:0] queue_size_ff;
   logic             reg_sel;
   brf_cmd_type      cmd;

   // register decode: one word per 4 bytes
   assign pready  = 1'b1;
   assign reg_sel = (paddr[CSR_ADDR_W-1:2] == REG_QUEUE_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_size_ff <= CNT_W'(DEPTH);
      end else if (psel && penable && pwrite && pready && reg_sel) begin
         queue_size_ff <= pwdata[CNT_W-1:0];
      end
   end

   assign prdata = reg_sel ? {{(32-CNT_W){1'b0}}, queue_size_ff} : 32'd0;

   brf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   brf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_kind        (req_kind),
      .req_data_in     (req_data_in),
      .queue_size      (queue_size_ff),
      .rsp_data_out    (rsp_data_out),
      .rsp_get_missed  (rsp_get_missed),
      .rsp_put_dropped (rsp_put_dropped),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_fill_count  (rsp_fill_count)
   );

   // checks
   `CHECK_NEXT(a_accept_exec, clock, reset, start && !busy, busy && !rsp_valid)
   `CHECK_NEXT(a_exec_resp, clock, reset, busy, rsp_valid && !busy)
   `CHECK_IMPLY(a_flags_excl, clock, reset, rsp_valid, !(rsp_get_missed && rsp_put_dropped))
   `CHECK_IMPLY(a_miss_empty, clock, reset, rsp_valid && rsp_get_missed, rsp_is_empty && (rsp_data_out == 8'd0))
   `CHECK_IMPLY(a_empty_count, clock, reset, rsp_valid, rsp_is_empty == (rsp_fill_count == '0))

endmodule

FILE: tb/byte_ring_fifo_checker.sv
// Checker for the byte ring FIFO: predicts every result and compares it.
module byte_ring_fifo_checker import brf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [1:0]            req_kind,
   input  logic [7:0]            req_data_in,
   input  logic                  rsp_valid,
   input  logic [7:0]            rsp_data_out,
   input  logic                  rsp_get_missed,
   input  logic                  rsp_put_dropped,
   input  logic                  rsp_is_empty,
   input  logic                  rsp_is_full,
   input  logic [CNT_W-1:0]      rsp_fill_count,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   input  logic [31:0]           prdata,
   input  logic                  pready,
   output int                    errors,
   output int                    outstanding,
   output int                    checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_W-1:0] SIZE_ADDR = CSR_ADDR_W'(4 * int'(REG_QUEUE_SIZE));

   typedef struct packed {
      logic [7:0]       data_out;
      logic             get_missed;
      logic             put_dropped;
      logic             is_empty;
      logic             is_full;
      logic [CNT_W-1:0] fill_count;
   } fifo_status_type;

   // shadow of the queue
   logic [7:0]      ring [DEPTH];
   int unsigned     wr_pos;
   int unsigned     rd_pos;
   int unsigned     held;
   logic [8:0]      size_reg;
   fifo_status_type status_queue [$];

   initial begin
      errors = 0;
      checked = 0;
      outstanding = 0;
   end

   // queue_size clamped to 1..DEPTH
   function automatic int unsigned active_size();
      if (size_reg == 0) return 1;
      if (size_reg > DEPTH) return DEPTH;
      return size_reg;
   endfunction

   function automatic int unsigned next_pos(int unsigned pos, int unsigned size);
      if (pos + 1 >= size || pos + 1 >= DEPTH) return 0;
      return pos + 1;
   endfunction

   // apply one word to the shadow queue and return the status it reports
   function automatic fifo_status_type apply_fifo_word(logic [1:0] kind, logic [7:0] din);
      fifo_status_type st;
      int unsigned     size;
      size = active_size();
      st = '0;
      case (kind)
         KIND_PUT: begin
            if (held < size) begin
               ring[wr_pos] = din;
               wr_pos = next_pos(wr_pos, size);
               held++;
            end else begin
               st.put_dropped = 1'b1;
            end
         end
         KIND_GET: begin
            if (held > 0) begin
               st.data_out = ring[rd_pos];
               rd_pos = next_pos(rd_pos, size);
               held--;
            end else begin
               st.get_missed = 1'b1;
            end
         end
         KIND_CLEAR: begin
            wr_pos = 0;
            rd_pos = 0;
            held = 0;
         end
         default: ;
      endcase
      st.is_empty = (held == 0);
      st.is_full = (held >= size);
      st.fill_count = CNT_W'(held);
      return st;
   endfunction

   task automatic compare_field(string name, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // watch result, command and register channels
   always @(posedge clock) begin
      fifo_status_type want;
      if (reset) begin
         wr_pos = 0;
         rd_pos = 0;
         held = 0;
         size_reg = 9'd256;
         status_queue.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (status_queue.size() == 0) begin
               errors++;
               $display("%0t: result with none expected, expected nothing, actual count %0d",
                        $time, rsp_fill_count);
            end else begin
               want = status_queue.pop_front();
               checked++;
               compare_field("data_out", want.data_out, rsp_data_out);
               compare_field("get_missed", want.get_missed, rsp_get_missed);
               compare_field("put_dropped", want.put_dropped, rsp_put_dropped);
               compare_field("is_empty", want.is_empty, rsp_is_empty);
               compare_field("is_full", want.is_full, rsp_is_full);
               compare_field("fill_count", want.fill_count, rsp_fill_count);
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            status_queue.push_back(apply_fifo_word(req_kind, req_data_in));
         if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1) begin
            if (pwrite && paddr == SIZE_ADDR) begin
               size_reg = pwdata[8:0];
            end else if (!pwrite && prdata !== {23'd0, size_reg}) begin
               errors++;
               $display("%0t: queue_size readback mismatch, expected %0d, actual %0d",
                        $time, size_reg, prdata);
            end
         end
      end
      outstanding <= status_queue.size();
   end

endmodule

FILE: tb/byte_ring_fifo_unit_tb.sv
// Testbench top of the byte ring FIFO: clock, reset, stimulus and verdict.
module byte_ring_fifo_unit_tb import brf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] SIZE_ADDR = CSR_ADDR_W'(4 * int'(REG_QUEUE_SIZE));
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASES = 8;
   localparam int PHASE_WORDS = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_kind = KIND_PUT;
   logic [7:0]            req_data_in = '0;
   logic                  rsp_valid;
   logic [7:0]            rsp_data_out;
   logic                  rsp_get_missed;
   logic                  rsp_put_dropped;
   logic                  rsp_is_empty;
   logic                  rsp_is_full;
   logic [CNT_W-1:0]      rsp_fill_count;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   int errors;
   int outstanding;
   int checked;
   int cycle_count = 0;
   int word_count = 0;
   int setting_count = 0;
   int idle_pct = 0;
   int cur_size = DEPTH;

   byte_ring_fifo_unit u_top (.*);

   byte_ring_fifo_checker u_checker (.*);

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, outstanding);
         $display("Verification failed");
         $finish;
      end
   end

   // issue one word, hold it until taken, then maybe go idle
   task automatic send_word(logic [1:0] kind, logic [7:0] data);
      start <= 1'b1;
      req_kind <= kind;
      req_data_in <= data;
      do @(posedge clock); while (busy !== 1'b0);
      word_count++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_data_in <= 8'($urandom);
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // stop sending until every expected result is back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic csr_access(logic is_write, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= SIZE_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // reprogram queue_size while idle, read it back, optionally clear
   task automatic set_queue_size(logic [8:0] sz, bit with_clear);
      drain();
      repeat (4) @(posedge clock);
      csr_access(1'b1, {23'($urandom), sz});
      @(posedge clock);
      csr_access(1'b0, 32'($urandom));
      setting_count++;
      cur_size = (sz == 0) ? 1 : (sz > DEPTH) ? DEPTH : sz;
      if (with_clear) send_word(KIND_CLEAR, 8'($urandom));
   endtask

   // data extremes, every kind, empty and full edges at tiny sizes
   task automatic run_directed();
      csr_access(1'b0, '0);
      send_word(KIND_GET, 8'($urandom));
      send_word(KIND_UNUSED, 8'hFF);
      send_word(KIND_CLEAR, 8'hA5);
      send_word(KIND_PUT, 8'h00);
      send_word(KIND_PUT, 8'hFF);
      send_word(KIND_PUT, 8'h7F);
      send_word(KIND_UNUSED, 8'h00);
      repeat (3) send_word(KIND_GET, 8'($urandom));
      send_word(KIND_GET, 8'($urandom));
      send_word(KIND_PUT, 8'h55);
      send_word(KIND_CLEAR, 8'($urandom));
      send_word(KIND_GET, 8'($urandom));
      // single entry queue
      set_queue_size(9'd1, 1'b1);
      send_word(KIND_PUT, 8'h3C);
      send_word(KIND_PUT, 8'hC3);
      send_word(KIND_GET, 8'($urandom));
      send_word(KIND_GET, 8'($urandom));
      // zero size behaves as one
      set_queue_size(9'd0, 1'b1);
      send_word(KIND_PUT, 8'hAA);
      send_word(KIND_PUT, 8'h01);
      send_word(KIND_GET, 8'($urandom));
   endtask

   // bursts of puts or gets with random data, plus clears and unused kinds
   task automatic run_phase(int words);
      int sent;
      int burst;
      logic [1:0] kind;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(99) < 10) begin
            kind = $urandom_range(1) ? KIND_CLEAR : KIND_UNUSED;
            burst = 1;
         end else begin
            kind = $urandom_range(1) ? KIND_PUT : KIND_GET;
            burst = $urandom_range(1, (cur_size + 2 < 24) ? cur_size + 2 : 24);
         end
         repeat (burst) send_word(kind, 8'($urandom));
         sent += burst;
         if ($urandom_range(39) == 0) drain();
      end
   endtask

   initial begin
      logic [8:0] phase_size [PHASES];
      int phase_pct [3];
      phase_size = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd2, 9'd1, 9'd1, 9'd300};
      phase_size[5] = 9'($urandom_range(3, 256));
      phase_size[6] = 9'($urandom_range(3, 16));
      phase_pct = '{0, 79, 24};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();

      // fill every store entry once, overflow, then read back the oldest bytes
      set_queue_size(9'd256, 1'b1);
      repeat (DEPTH + 1) send_word(KIND_PUT, 8'($urandom));
      repeat (16) send_word(KIND_GET, 8'($urandom));

      // random phases; every entry is written, so a resize may skip the clear
      for (int p = 0; p < PHASES; p++) begin
         set_queue_size(phase_size[p], $urandom_range(99) < 70);
         idle_pct = phase_pct[p % 3];
         run_phase(PHASE_WORDS);
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Covered edge cases, a full-depth fill with overflow, and %0d random phases.",
               PHASES);
      $display("%0d words sent, %0d results checked, %0d size settings.",
               word_count, checked, setting_count);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
